// ===== rtl/core/text_console_writer_defines.svh =====
// Assertion macros shared by the console RTL.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Check a property on every rising clk_i edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every rising clk_i edge, reset included.
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== rtl/core/tcw_pkg.sv =====
// Shared widths, codes and constants of the text console.
package tcw_pkg;

  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int NIBBLE_W  = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = NIBBLE_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_FG_IDX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_IDX = 1'd1;

  localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'h20;
  localparam logic [NIBBLE_W-1:0] FG_RESET     = 4'hF;
  localparam logic [NIBBLE_W-1:0] BG_RESET     = 4'h0;
  localparam logic [15:0]         RESET_CELL   = 16'h0F20;

endpackage

// ===== rtl/core/tcw_if.sv =====
// Handshake channels for console requests and results.
interface tcw_in_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [CHAR_W-1:0]    char_code;
  logic [INDEX_W-1:0]   cell_index;

  modport source(output valid, operation, char_code, cell_index, input ready);
  modport sink(input valid, operation, char_code, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    cell_char;
  logic [CHAR_W-1:0]    cell_color;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [COL_OUT_W-1:0] cursor_col;

  modport source(output valid, cell_char, cell_color, cursor_row, cursor_col, input ready);
  modport sink(input valid, cell_char, cell_color, cursor_row, cursor_col, output ready);
endinterface

// ===== rtl/core/text_console_writer.sv =====
// Text console: cursor sequencer over a single-port-write character-cell store.
//
//   channel  dir  carries                                   transfer when
//   in_if    in   operation, char_code, cell_index          valid && ready
//   out_if   out  cell_char, cell_color, cursor_row/col     valid && ready
//   cfg      in   cfg_idx_i, cfg_data_i (fg, bg nibbles)    cfg_we_i
//
// A put is handled in ST_PUT and a read in ST_RDATA; a wrap passes through ST_PUT
// once more, a newline does not. Clear blanks every cell, and a scroll copies each
// row up and blanks the last: the store has one write port, so every cell is a cycle.
// After reset every cell of the store is swept to white-on-black spaces before the
// first request is taken.
// The result sits in an output register, so a new request is taken while it waits.
`include "text_console_writer_defines.svh"

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tcw_in_if.sink                in_if,
  tcw_out_if.source             out_if
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PTR_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [PTR_W-1:0]  PTR_END     = PTR_W'(CELLS);
  localparam logic [PTR_W-1:0]  PTR_LAST    = PTR_W'(CELLS - 1);
  localparam logic [PTR_W-1:0]  PTR_LASTROW = PTR_W'((ROWS - 1) * COLUMNS);
  localparam logic [PTR_W-1:0]  PTR_COLS    = PTR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_MAX     = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] BASE_STEP   = ADDR_W'(COLUMNS);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_INIT   = 8'b0000_0010,
    ST_CLEAR  = 8'b0000_0100,
    ST_PUT    = 8'b0000_1000,
    ST_SCROLL = 8'b0001_0000,
    ST_FILL   = 8'b0010_0000,
    ST_RDATA  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  logic                copy_valid_q, copy_valid_d;
  logic [ADDR_W-1:0]   wptr_q;
  logic [NIBBLE_W-1:0] fg_q, bg_q;
  logic [CHAR_W-1:0]   ch_q;
  logic                rd_ok_q;
  logic [15:0]         rdata_q;
  logic [CHAR_W-1:0]   res_char_q, res_char_d, res_color_q, res_color_d;

  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    out_char_q, out_color_q;
  logic [ROW_OUT_W-1:0] out_row_q;
  logic [COL_OUT_W-1:0] out_col_q;

  logic [15:0] mem [CELLS];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  logic              in_ready, in_xfer, out_free, out_load;
  logic              fin;
  logic [CHAR_W-1:0] fin_char, fin_color, load_char, load_color;
  logic [CHAR_W-1:0] color;
  logic [15:0]       blank;

  assign color    = {bg_q, fg_q};
  assign blank    = {color, SPACE_CODE};
  assign in_ready = (state_q == ST_IDLE);
  assign in_xfer  = in_if.valid && in_ready;
  assign out_free = !out_valid_q || out_if.ready;

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    base_d       = base_q;
    ptr_d        = ptr_q;
    copy_valid_d = 1'b0;
    res_char_d   = res_char_q;
    res_color_d  = res_color_q;
    mem_we       = 1'b0;
    mem_waddr    = base_q + ADDR_W'(col_q);
    mem_wdata    = {color, ch_q};
    mem_re       = 1'b0;
    mem_raddr    = ADDR_W'(in_if.cell_index);
    fin          = 1'b0;
    fin_char     = '0;
    fin_color    = '0;
    out_load     = 1'b0;
    load_char    = res_char_q;
    load_color   = res_color_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (op_e'(in_if.operation))
            OP_PUT: state_d = ST_PUT;
            OP_CLEAR: begin
              ptr_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_READ: begin
              mem_re  = int'(in_if.cell_index) < CELLS;
              state_d = ST_RDATA;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(ptr_q);
        mem_wdata = RESET_CELL;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == PTR_LAST) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(ptr_q);
        mem_wdata = blank;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == PTR_LAST) begin
          fin = 1'b1;
        end
      end
      ST_PUT: begin
        if (ch_q == NEWLINE_CODE || col_q >= COL_MAX) begin
          col_d = '0;
          if (row_q != ROW_LAST) begin
            row_d  = row_q + 1'b1;
            base_d = base_q + BASE_STEP;
            // a wrapped character stays here and is written next cycle
            fin = (ch_q == NEWLINE_CODE);
          end else begin
            ptr_d   = PTR_COLS;
            state_d = ST_SCROLL;
          end
        end else begin
          mem_we = 1'b1;
          col_d  = col_q + 1'b1;
          fin    = 1'b1;
        end
      end
      ST_SCROLL: begin
        // read cell i, write it in the next cycle at i - COLUMNS
        if (copy_valid_q) begin
          mem_we    = 1'b1;
          mem_waddr = wptr_q;
          mem_wdata = rdata_q;
        end
        if (ptr_q != PTR_END) begin
          mem_re       = 1'b1;
          mem_raddr    = ADDR_W'(ptr_q);
          ptr_d        = ptr_q + 1'b1;
          copy_valid_d = 1'b1;
        end else begin
          ptr_d   = PTR_LASTROW;
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(ptr_q);
        mem_wdata = blank;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == PTR_LAST) begin
          ptr_d = '0;
          if (ch_q == NEWLINE_CODE) begin
            fin = 1'b1;
          end else begin
            state_d = ST_PUT;
          end
        end
      end
      ST_RDATA: begin
        fin = 1'b1;
        if (rd_ok_q) begin
          fin_char  = rdata_q[7:0];
          fin_color = rdata_q[15:8];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (fin) begin
      if (out_free) begin
        out_load   = 1'b1;
        load_char  = fin_char;
        load_color = fin_color;
        state_d    = ST_IDLE;
      end else begin
        res_char_d  = fin_char;
        res_color_d = fin_color;
        state_d     = ST_DONE;
      end
    end

    out_valid_d = out_load || (out_valid_q && !out_if.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      col_q        <= '0;
      row_q        <= '0;
      base_q       <= '0;
      ptr_q        <= '0;
      copy_valid_q <= 1'b0;
      fg_q         <= FG_RESET;
      bg_q         <= BG_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      base_q       <= base_d;
      ptr_q        <= ptr_d;
      copy_valid_q <= copy_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FG_IDX: fg_q <= cfg_data_i;
          CFG_BG_IDX: bg_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q    <= in_if.char_code;
      rd_ok_q <= int'(in_if.cell_index) < CELLS;
    end
    wptr_q      <= ADDR_W'(ptr_q - PTR_COLS);
    res_char_q  <= res_char_d;
    res_color_q <= res_color_d;
    if (out_load) begin
      out_char_q  <= load_char;
      out_color_q <= load_color;
      out_row_q   <= ROW_OUT_W'(row_d);
      out_col_q   <= COL_OUT_W'(col_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid_q;
  assign out_if.cell_char  = out_char_q;
  assign out_if.cell_color = out_color_q;
  assign out_if.cursor_row = out_row_q;
  assign out_if.cursor_col = out_col_q;

  `TCW_ASSERT(a_col_range, col_q <= COL_MAX, "cursor column past row width")
  `TCW_ASSERT(a_row_range, int'(row_q) < ROWS, "cursor row past last row")
  `TCW_ASSERT(a_base_tracks_row, base_q == ADDR_W'(int'(row_q) * COLUMNS), "row base out of step")
  `TCW_ASSERT(a_put_in_row, (state_q == ST_PUT && mem_we) |-> col_q < COL_MAX, "put outside the row")
  `TCW_ASSERT_ALWAYS(a_copy_in_scroll, copy_valid_q |-> state_q == ST_SCROLL, "copy outside scroll")

endmodule
